FILE: rtl/core/md5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WADDR_W  = 4;   // 16 message words per block
  localparam int unsigned LANE_W   = 2;   // 4 bytes per word
  localparam int unsigned POS_W    = 6;   // 64 bytes per block
  localparam int unsigned LEN_W    = 64;

  localparam logic [WORD_W-1:0] INIT_A = 32'h67452301;
  localparam logic [WORD_W-1:0] INIT_B = 32'hefcdab89;
  localparam logic [WORD_W-1:0] INIT_C = 32'h98badcfe;
  localparam logic [WORD_W-1:0] INIT_D = 32'h10325476;
  localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;
  localparam logic [POS_W-1:0]  LEN_POS  = 6'd56;
  localparam logic [POS_W-1:0]  LAST_POS = 6'd63;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef logic [3:0][WORD_W-1:0] words_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PRE1,
    ST_PRE2,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  // Controls from the sequencer to the round unit.
  typedef struct packed {
    logic load;   // take chain words into the working registers
    logic prime;  // form the first round's a + K + W
    logic step;   // run one round
  } rnd_ctl_t;

  // Message word index used by each round.
  function automatic logic [WADDR_W-1:0] md5_widx(input logic [POS_W-1:0] r);
    logic [WADDR_W-1:0] lo;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    md5_widx = lo;
      2'd1:    md5_widx = 4'(lo * 4'd5 + 4'd1);
      2'd2:    md5_widx = 4'(lo * 4'd3 + 4'd5);
      default: md5_widx = 4'(lo * 4'd7);
    endcase
  endfunction

  // Left rotate amount for each round.
  function automatic logic [4:0] md5_shift(input logic [POS_W-1:0] r);
    case ({r[5:4], r[1:0]})
      4'd0:    md5_shift = 5'd7;
      4'd1:    md5_shift = 5'd12;
      4'd2:    md5_shift = 5'd17;
      4'd3:    md5_shift = 5'd22;
      4'd4:    md5_shift = 5'd5;
      4'd5:    md5_shift = 5'd9;
      4'd6:    md5_shift = 5'd14;
      4'd7:    md5_shift = 5'd20;
      4'd8:    md5_shift = 5'd4;
      4'd9:    md5_shift = 5'd11;
      4'd10:   md5_shift = 5'd16;
      4'd11:   md5_shift = 5'd23;
      4'd12:   md5_shift = 5'd6;
      4'd13:   md5_shift = 5'd10;
      4'd14:   md5_shift = 5'd15;
      default: md5_shift = 5'd21;
    endcase
  endfunction

  // Additive round constants.
  function automatic logic [WORD_W-1:0] md5_k(input logic [POS_W-1:0] r);
    case (r)
      6'd0:    md5_k = 32'hd76aa478;
      6'd1:    md5_k = 32'he8c7b756;
      6'd2:    md5_k = 32'h242070db;
      6'd3:    md5_k = 32'hc1bdceee;
      6'd4:    md5_k = 32'hf57c0faf;
      6'd5:    md5_k = 32'h4787c62a;
      6'd6:    md5_k = 32'ha8304613;
      6'd7:    md5_k = 32'hfd469501;
      6'd8:    md5_k = 32'h698098d8;
      6'd9:    md5_k = 32'h8b44f7af;
      6'd10:   md5_k = 32'hffff5bb1;
      6'd11:   md5_k = 32'h895cd7be;
      6'd12:   md5_k = 32'h6b901122;
      6'd13:   md5_k = 32'hfd987193;
      6'd14:   md5_k = 32'ha679438e;
      6'd15:   md5_k = 32'h49b40821;
      6'd16:   md5_k = 32'hf61e2562;
      6'd17:   md5_k = 32'hc040b340;
      6'd18:   md5_k = 32'h265e5a51;
      6'd19:   md5_k = 32'he9b6c7aa;
      6'd20:   md5_k = 32'hd62f105d;
      6'd21:   md5_k = 32'h02441453;
      6'd22:   md5_k = 32'hd8a1e681;
      6'd23:   md5_k = 32'he7d3fbc8;
      6'd24:   md5_k = 32'h21e1cde6;
      6'd25:   md5_k = 32'hc33707d6;
      6'd26:   md5_k = 32'hf4d50d87;
      6'd27:   md5_k = 32'h455a14ed;
      6'd28:   md5_k = 32'ha9e3e905;
      6'd29:   md5_k = 32'hfcefa3f8;
      6'd30:   md5_k = 32'h676f02d9;
      6'd31:   md5_k = 32'h8d2a4c8a;
      6'd32:   md5_k = 32'hfffa3942;
      6'd33:   md5_k = 32'h8771f681;
      6'd34:   md5_k = 32'h6d9d6122;
      6'd35:   md5_k = 32'hfde5380c;
      6'd36:   md5_k = 32'ha4beea44;
      6'd37:   md5_k = 32'h4bdecfa9;
      6'd38:   md5_k = 32'hf6bb4b60;
      6'd39:   md5_k = 32'hbebfbc70;
      6'd40:   md5_k = 32'h289b7ec6;
      6'd41:   md5_k = 32'heaa127fa;
      6'd42:   md5_k = 32'hd4ef3085;
      6'd43:   md5_k = 32'h04881d05;
      6'd44:   md5_k = 32'hd9d4d039;
      6'd45:   md5_k = 32'he6db99e5;
      6'd46:   md5_k = 32'h1fa27cf8;
      6'd47:   md5_k = 32'hc4ac5665;
      6'd48:   md5_k = 32'hf4292244;
      6'd49:   md5_k = 32'h432aff97;
      6'd50:   md5_k = 32'hab9423a7;
      6'd51:   md5_k = 32'hfc93a039;
      6'd52:   md5_k = 32'h655b59c3;
      6'd53:   md5_k = 32'h8f0ccc92;
      6'd54:   md5_k = 32'hffeff47d;
      6'd55:   md5_k = 32'h85845dd1;
      6'd56:   md5_k = 32'h6fa87e4f;
      6'd57:   md5_k = 32'hfe2ce6e0;
      6'd58:   md5_k = 32'ha3014314;
      6'd59:   md5_k = 32'h4e0811a1;
      6'd60:   md5_k = 32'hf7537e82;
      6'd61:   md5_k = 32'hbd3af235;
      6'd62:   md5_k = 32'h2ad7d2bb;
      default: md5_k = 32'heb86d391;
    endcase
  endfunction

endpackage

FILE: rtl/core/md5_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_buf
// Block buffer: 16 words of 4 byte lanes, byte write, registered word read.
// ----------------------------------------------------------------------------
module md5_buf (
  input  logic                        clk,
  input  logic                        we,
  input  logic [md5_pkg::WADDR_W-1:0] waddr,
  input  logic [md5_pkg::LANE_W-1:0]  wlane,
  input  logic [md5_pkg::BYTE_W-1:0]  wdata,
  input  logic [md5_pkg::WADDR_W-1:0] raddr,
  output logic [md5_pkg::WORD_W-1:0]  rdata
);
  import md5_pkg::*;

  logic [3:0][BYTE_W-1:0] mem_r [1 << WADDR_W];
  logic [WORD_W-1:0]      rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr][wlane] <= wdata;
    end
  end

  // Byte lane 0 is the least significant byte of the word.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/md5_rnd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_rnd
// Shared round unit: working registers a..d and one MD5 round per cycle.
// ----------------------------------------------------------------------------
module md5_rnd (
  input  logic                       clk,
  input  md5_pkg::rnd_ctl_t          ctl,
  input  logic [md5_pkg::POS_W-1:0]  rnd,
  input  md5_pkg::words_t            chain,
  input  logic [md5_pkg::WORD_W-1:0] w,
  output md5_pkg::words_t            work
);
  import md5_pkg::*;

  logic [WORD_W-1:0]   a_r, b_r, c_r, d_r, s_r;
  logic [WORD_W-1:0]   f, sum, b_new, s_nxt, s_base;
  logic [2*WORD_W-1:0] rot;
  logic [POS_W-1:0]    kidx;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    // s_r already holds a + K + W for this round
    sum   = f + s_r;
    rot   = {sum, sum} << md5_shift(rnd);
    b_new = b_r + rot[2*WORD_W-1:WORD_W];
    // next round's a is this round's d
    kidx   = ctl.step ? POS_W'(rnd + 1'b1) : '0;
    s_base = ctl.step ? d_r : a_r;
    s_nxt  = s_base + w + md5_k(kidx);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= chain[0];
      b_r <= chain[1];
      c_r <= chain[2];
      d_r <= chain[3];
    end else if (ctl.step) begin
      a_r <= d_r;
      b_r <= b_new;
      c_r <= b_r;
      d_r <= c_r;
    end
    if (ctl.prime || ctl.step) begin
      s_r <= s_nxt;
    end
  end

  assign work[0] = a_r;
  assign work[1] = b_r;
  assign work[2] = c_r;
  assign work[3] = d_r;

endmodule

FILE: rtl/core/md5_message_digest_top.sv
`timescale 1ns / 1ps
// Data byte: taken while idle; the 64th byte of a block then holds the input
// stalled through PRE1, PRE2, 64 rounds on the shared round unit, one chain add.
// Finish: pads bytes fill..63 and processes the block, plus one more padded block
// when fill > 55, then registers the digest. The input is stalled meanwhile.
// Reset clears control and restores the initial chain words; the block buffer is
// left undefined and is always written before it is read.
// ----------------------------------------------------------------------------
// md5_message_digest_top
// MD5 digest engine: byte input, block buffer, iterative round unit, padding.
// ----------------------------------------------------------------------------
module md5_message_digest_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic [md5_pkg::BYTE_W-1:0] in_data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [md5_pkg::WORD_W-1:0] out_digest_word0,
  output logic [md5_pkg::WORD_W-1:0] out_digest_word1,
  output logic [md5_pkg::WORD_W-1:0] out_digest_word2,
  output logic [md5_pkg::WORD_W-1:0] out_digest_word3
);
  import md5_pkg::*;

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   fill_r, pos_r, rnd_r;
  logic [LEN_W-1:0]   msg_bits_r;
  logic               mark_r, last_r, pad_r;
  words_t             chain_r, work, out_words_r;
  logic               out_valid_r;

  logic               in_xfer, emit;
  logic               buf_we;
  logic [WADDR_W-1:0] buf_waddr, buf_raddr;
  logic [LANE_W-1:0]  buf_wlane;
  logic [BYTE_W-1:0]  buf_wdata, pad_byte;
  logic [WORD_W-1:0]  buf_rdata;
  rnd_ctl_t           ctl;

  md5_buf u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wlane (buf_wlane),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  md5_rnd u_rnd (
    .clk   (clk),
    .ctl   (ctl),
    .rnd   (rnd_r),
    .chain (chain_r),
    .w     (buf_rdata),
    .work  (work)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_FINISH) begin
            state_nxt = ST_PAD;
          end else if (fill_r == LAST_POS) begin
            state_nxt = ST_PRE1;
          end
        end
      end
      ST_PAD:   if (pos_r == LAST_POS) state_nxt = ST_PRE1;
      ST_PRE1:  state_nxt = ST_PRE2;
      ST_PRE2:  state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == LAST_POS) state_nxt = ST_ADD;
      ST_ADD: begin
        if (!pad_r) begin
          state_nxt = ST_IDLE;
        end else if (last_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_EMIT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Padding byte: marker, zeros, then the bit count little-endian
  always_comb begin
    if (mark_r) begin
      pad_byte = PAD_MARK;
    end else if (last_r && pos_r >= LEN_POS) begin
      pad_byte = msg_bits_r[{pos_r[2:0], 3'b000} +: BYTE_W];
    end else begin
      pad_byte = '0;
    end
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    in_xfer   = 1'b0;
    emit      = 1'b0;
    buf_we    = 1'b0;
    buf_waddr = fill_r[POS_W-1:LANE_W];
    buf_wlane = fill_r[LANE_W-1:0];
    buf_wdata = in_data_byte;
    buf_raddr = md5_widx('0);
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        in_xfer  = in_valid;
        buf_we   = in_valid && (in_kind == KIND_DATA);
      end
      ST_PAD: begin
        buf_we    = 1'b1;
        buf_waddr = pos_r[POS_W-1:LANE_W];
        buf_wlane = pos_r[LANE_W-1:0];
        buf_wdata = pad_byte;
      end
      ST_PRE1: begin
        ctl.load = 1'b1;
      end
      ST_PRE2: begin
        ctl.prime = 1'b1;
        buf_raddr = md5_widx(POS_W'(1));
      end
      ST_ROUND: begin
        ctl.step  = 1'b1;
        // fetch the word for round rnd + 2: it passes the buffer's read register, then the pre-add into s_r
        buf_raddr = md5_widx(POS_W'(rnd_r + 2'd2));
      end
      ST_ADD: begin
      end
      ST_EMIT: begin
        emit = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      pos_r       <= '0;
      rnd_r       <= '0;
      msg_bits_r  <= '0;
      mark_r      <= 1'b0;
      last_r      <= 1'b0;
      pad_r       <= 1'b0;
      out_valid_r <= 1'b0;
      chain_r     <= {INIT_D, INIT_C, INIT_B, INIT_A};
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        if (in_kind == KIND_DATA) begin
          fill_r     <= POS_W'(fill_r + 1'b1);
          msg_bits_r <= msg_bits_r + LEN_W'(8);
        end else begin
          pad_r  <= 1'b1;
          mark_r <= 1'b1;
          pos_r  <= fill_r;
          last_r <= (fill_r < LEN_POS);
        end
      end
      if (state_r == ST_PAD) begin
        pos_r  <= POS_W'(pos_r + 1'b1);
        mark_r <= 1'b0;
      end
      if (state_r == ST_ROUND) begin
        rnd_r <= POS_W'(rnd_r + 1'b1);
      end
      if (state_r == ST_ADD) begin
        for (int i = 0; i < 4; i++) begin
          chain_r[i] <= chain_r[i] + work[i];
        end
        // spill block done: next block carries the length
        if (pad_r && !last_r) begin
          last_r <= 1'b1;
          pos_r  <= '0;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        chain_r     <= {INIT_D, INIT_C, INIT_B, INIT_A};
        fill_r      <= '0;
        msg_bits_r  <= '0;
        pad_r       <= 1'b0;
        last_r      <= 1'b0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_words_r <= chain_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digest_word0 = out_words_r[0];
  assign out_digest_word1 = out_words_r[1];
  assign out_digest_word2 = out_words_r[2];
  assign out_digest_word3 = out_words_r[3];

endmodule

FILE: rtl/core/md5_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_chk
// Port-level checks for the MD5 digest engine, bound to the top level.
// ----------------------------------------------------------------------------
module md5_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_kind,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [md5_pkg::WORD_W-1:0] out_digest_word0,
  input logic [md5_pkg::WORD_W-1:0] out_digest_word1,
  input logic [md5_pkg::WORD_W-1:0] out_digest_word2,
  input logic [md5_pkg::WORD_W-1:0] out_digest_word3
);
  import md5_pkg::*;

  // Hold a stalled digest
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word0) &&
      $stable(out_digest_word1) && $stable(out_digest_word2) &&
      $stable(out_digest_word3))
    else $error("digest changed while stalled");

  // A finish transfer starts padding, so the input goes busy
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_FINISH) |=> in_stall)
    else $error("input not busy after finish");

  // A new digest only follows a busy period
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("digest appeared without processing");

  // A data byte never produces a digest directly
  a_data_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_DATA) |=> !$rose(out_valid))
    else $error("digest after data byte");

endmodule

bind md5_message_digest_top md5_chk u_md5_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_digest_word0 (out_digest_word0),
  .out_digest_word1 (out_digest_word1),
  .out_digest_word2 (out_digest_word2),
  .out_digest_word3 (out_digest_word3)
);
